// ===== rtl/core/sorted_timer_queue_top_macros.svh =====
// Assertion macros for the sorted timer queue.
`ifndef SORTED_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_TIMER_QUEUE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define STQ_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("stq check failed");
`define STQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stq check failed");
`else
`define STQ_ASSERT(lbl, cond)
`define STQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/stq_pkg.sv =====
// Shared types and constants of the sorted timer queue.
package stq_pkg;
  localparam int DefCapacity = 16;
  localparam int DefTimeBits = 32;
  localparam int HandleBits  = 8;
  localparam int FieldTimeBits = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  localparam logic KIND_DONE    = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;
endpackage

// ===== rtl/core/sorted_timer_queue_top.sv =====
// Sorted timer queue: up to CAPACITY timers kept in one slot RAM in expiry order.
// Each operation walks the slot RAM through its single read port, reading and then
// checking each entry visited. Add scans, shifts later entries up and inserts; adjust
// moves the timer past later entries due no later than its new expiry; delete shifts
// later entries down; tick emits and removes each due timer from the head. The next
// transfer is taken once the done result has moved into the output register, even
// while it still waits there. Results: every operation ends with a done result with
// tlast set; tick first gives one expired handle per due timer.
module sorted_timer_queue_top #(
  parameter int CAPACITY  = stq_pkg::DefCapacity,
  parameter int TIME_BITS = stq_pkg::DefTimeBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // handle[7:0], expire_time[39:8], now[71:40]
  input  logic [1:0]  s_tuser,  // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,  // expired_handle[7:0], status[9:8], zero[15:10]
  output logic        m_tuser,  // kind[0]
  output logic        m_tlast
);
  import stq_pkg::*;
`include "sorted_timer_queue_top_macros.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = HandleBits + TIME_BITS;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_SCAN_RD  = 13'b0000000000010,
    S_SCAN_CHK = 13'b0000000000100,
    S_SHUP_RD  = 13'b0000000001000,
    S_SHUP_WR  = 13'b0000000010000,
    S_INS      = 13'b0000000100000,
    S_SHDN_RD  = 13'b0000001000000,
    S_SHDN_WR  = 13'b0000010000000,
    S_ADJ_RD   = 13'b0000100000000,
    S_ADJ_CHK  = 13'b0001000000000,
    S_TICK_RD  = 13'b0010000000000,
    S_TICK_CHK = 13'b0100000000000,
    S_EMIT     = 13'b1000000000000
  } state_t;

  localparam state_t S_DONE_UNUSED = S_IDLE;

  state_t state;
  logic   done_pend;

  op_t                   op;
  logic [HandleBits-1:0] hnd;
  logic [TIME_BITS-1:0]  tval;
  logic [TIME_BITS-1:0]  nowv;
  status_t               status;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         pos;
  logic                  pos_set;
  logic                  found;
  logic [HandleBits-1:0] ehandle;

  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;

  logic [TIME_BITS-1:0]  r_exp;
  logic [HandleBits-1:0] r_hnd;
  logic [CW-1:0]         idx_p1;
  logic [CW-1:0]         idx_m1;
  logic [63:0]           t64;
  logic [63:0]           n64;
  logic                  out_free;

  assign r_exp    = rdata[TIME_BITS-1:0];
  assign r_hnd    = rdata[EW-1:TIME_BITS];
  assign idx_p1   = idx + CW'(1);
  assign idx_m1   = idx - CW'(1);
  assign t64      = {32'b0, s_tdata[39:8]};
  assign n64      = {32'b0, s_tdata[71:40]};
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && !done_pend;

  stq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = {hnd, tval};
    raddr = idx[AW-1:0];
    unique case (state)
      S_SHUP_RD: raddr = idx_m1[AW-1:0];
      S_SHUP_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      S_INS: begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
      end
      S_SHDN_RD: raddr = idx_p1[AW-1:0];
      S_SHDN_WR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      S_ADJ_RD: begin
        raddr = idx_p1[AW-1:0];
        we    = !(idx_p1 < count);
      end
      S_ADJ_CHK: begin
        we = 1'b1;
        if (r_exp <= tval) begin
          wdata = rdata;
        end
      end
      S_TICK_RD: raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done_pend <= 1'b0;
      count     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (done_pend && out_free) begin
        m_tvalid  <= 1'b1;
        m_tuser   <= KIND_DONE;
        m_tdata   <= {6'b0, status, 8'b0};
        m_tlast   <= 1'b1;
        done_pend <= 1'b0;
      end else if (m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            op      <= op_t'(s_tuser);
            hnd     <= s_tdata[7:0];
            tval    <= t64[TIME_BITS-1:0];
            nowv    <= n64[TIME_BITS-1:0];
            status  <= ST_OK;
            idx     <= '0;
            pos     <= count;
            pos_set <= 1'b0;
            found   <= 1'b0;
            if (op_t'(s_tuser) == OP_TICK) begin
              state <= S_TICK_RD;
            end else if (op_t'(s_tuser) == OP_ADD && count == CapC) begin
              status    <= ST_FULL;
              done_pend <= 1'b1;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          if (idx == count) begin
            if (op == OP_ADD) begin
              if (found) begin
                status    <= ST_FULL;
                done_pend <= 1'b1;
                state     <= S_IDLE;
              end else if (pos == count) begin
                state <= S_INS;
              end else begin
                idx   <= count;
                state <= S_SHUP_RD;
              end
            end else if (!found) begin
              status    <= ST_ABSENT;
              done_pend <= 1'b1;
              state     <= S_IDLE;
            end else begin
              idx   <= pos;
              state <= (op == OP_DELETE) ? S_SHDN_RD : S_ADJ_RD;
            end
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (r_hnd == hnd && !found) begin
            found <= 1'b1;
            if (op != OP_ADD) begin
              pos <= idx;
            end
          end
          if (op == OP_ADD && !pos_set && r_exp > tval) begin
            pos     <= idx;
            pos_set <= 1'b1;
          end
          idx   <= idx_p1;
          state <= S_SCAN_RD;
        end
        S_SHUP_RD: state <= S_SHUP_WR;
        S_SHUP_WR: begin
          idx   <= idx_m1;
          state <= (idx_m1 == pos) ? S_INS : S_SHUP_RD;
        end
        S_INS: begin
          count     <= count + CW'(1);
          done_pend <= 1'b1;
          state     <= S_IDLE;
        end
        S_SHDN_RD: begin
          if (!(idx_p1 < count)) begin
            count <= count - CW'(1);
            if (op == OP_TICK) begin
              state <= S_TICK_RD;
            end else begin
              done_pend <= 1'b1;
              state     <= S_IDLE;
            end
          end else begin
            state <= S_SHDN_WR;
          end
        end
        S_SHDN_WR: begin
          idx   <= idx_p1;
          state <= S_SHDN_RD;
        end
        S_ADJ_RD: begin
          if (idx_p1 < count) begin
            state <= S_ADJ_CHK;
          end else begin
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_ADJ_CHK: begin
          if (r_exp <= tval) begin
            idx   <= idx_p1;
            state <= S_ADJ_RD;
          end else begin
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_TICK_RD: begin
          if (count == '0) begin
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_TICK_CHK;
          end
        end
        S_TICK_CHK: begin
          if (r_exp <= nowv) begin
            ehandle <= r_hnd;
            state   <= S_EMIT;
          end else begin
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= KIND_EXPIRED;
            m_tdata  <= {6'b0, ST_OK, ehandle};
            m_tlast  <= 1'b0;
            idx      <= '0;
            state    <= S_SHDN_RD;
          end
        end
        default: state <= S_DONE_UNUSED;
      endcase
    end
  end

  `STQ_ASSERT(a_count_range, count <= CapC)
  `STQ_ASSERT(a_write_in_range, !we || ({1'b0, waddr} <= {1'b0, count}))
  `STQ_ASSERT_NEXT(a_count_step, 1'b1,
    count == $past(count) || count == $past(count) + CW'(1) ||
    count + CW'(1) == $past(count))
endmodule

// ===== rtl/core/stq_ram.sv =====
// Generic RAM, one write port, one read port with registered read data.
module stq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== tb/sorted_timer_queue_top_tb.sv =====
// Testbench for the sorted timer queue: directed table plus random operations, checked by a predictor.
`timescale 1ns / 100ps
module sorted_timer_queue_top_tb;
  import stq_pkg::*;

  localparam int Cap = 16;

  typedef struct packed {
    logic       kind;
    logic [7:0] hnd;
    status_t    status;
    logic       last;
  } timer_result_t;

  typedef struct {
    op_t         op;
    logic [7:0]  hnd;
    logic [31:0] expiry;
    logic [31:0] now;
    logic        typed;
    status_t     status;
  } timer_cmd_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  sorted_timer_queue_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  logic [7:0]    q_hnd[Cap];
  logic [31:0]   q_exp[Cap];
  int            q_cnt;
  timer_result_t pending[$];
  timer_cmd_t    table_rows[$];
  int            errors;
  int            idle_cycles;
  bit            no_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int find_timer(logic [7:0] h);
    for (int i = 0; i < q_cnt; i++) if (q_hnd[i] == h) return i;
    return Cap;
  endfunction

  function automatic void remove_at(int p);
    for (int i = p; i + 1 < q_cnt; i++) begin
      q_hnd[i] = q_hnd[i + 1];
      q_exp[i] = q_exp[i + 1];
    end
    q_cnt--;
  endfunction

  function automatic void schedule_op(timer_cmd_t c);
    status_t st;
    int p;
    st = ST_OK;
    case (c.op)
      OP_ADD: begin
        if (q_cnt >= Cap || find_timer(c.hnd) != Cap) begin
          st = ST_FULL;
        end else begin
          p = 0;
          while (p < q_cnt && q_exp[p] <= c.expiry) p++;
          for (int i = q_cnt; i > p; i--) begin
            q_hnd[i] = q_hnd[i - 1];
            q_exp[i] = q_exp[i - 1];
          end
          q_hnd[p] = c.hnd;
          q_exp[p] = c.expiry;
          q_cnt++;
        end
      end
      OP_ADJUST: begin
        p = find_timer(c.hnd);
        if (p == Cap) begin
          st = ST_ABSENT;
        end else begin
          while (p + 1 < q_cnt && q_exp[p + 1] <= c.expiry) begin
            q_hnd[p] = q_hnd[p + 1];
            q_exp[p] = q_exp[p + 1];
            p++;
          end
          q_hnd[p] = c.hnd;
          q_exp[p] = c.expiry;
        end
      end
      OP_DELETE: begin
        p = find_timer(c.hnd);
        if (p == Cap) st = ST_ABSENT;
        else remove_at(p);
      end
      default: begin
        while (q_cnt > 0 && q_exp[0] <= c.now) begin
          pending.push_back('{KIND_EXPIRED, q_hnd[0], ST_OK, 1'b0});
          remove_at(0);
        end
      end
    endcase
    if (c.typed && st != c.status) begin
      $error("table status expected %0d got %0d", c.status, st);
      errors++;
    end
    pending.push_back('{KIND_DONE, 8'd0, st, 1'b1});
  endfunction

  task automatic send(timer_cmd_t c);
    while (!no_idle && $urandom_range(99) < 25) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.op;
    s_tdata  <= {c.now, c.expiry, c.hnd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    schedule_op(c);
    @(negedge clk);
  endtask

  function automatic timer_cmd_t mk(op_t op, logic [7:0] h, logic [31:0] e,
                                    logic [31:0] n, bit typed, status_t st);
    timer_cmd_t c;
    c.op = op; c.hnd = h; c.expiry = e; c.now = n; c.typed = typed; c.status = st;
    return c;
  endfunction

  // output side: ready and checking
  always @(negedge clk) m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 25);

  always @(posedge clk) begin
    timer_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      idle_cycles <= 0;
      if (pending.size() == 0) begin
        $error("unexpected transfer");
        errors++;
      end else begin
        exp_r = pending.pop_front();
        if (m_tuser !== exp_r.kind) begin
          $error("kind expected %0d got %0d", exp_r.kind, m_tuser); errors++;
        end
        if (m_tdata[7:0] !== exp_r.hnd) begin
          $error("expired_handle expected %0d got %0d", exp_r.hnd, m_tdata[7:0]); errors++;
        end
        if (m_tdata[9:8] !== exp_r.status) begin
          $error("status expected %0d got %0d", exp_r.status, m_tdata[9:8]); errors++;
        end
        if (m_tlast !== exp_r.last) begin
          $error("last expected %0d got %0d", exp_r.last, m_tlast); errors++;
        end
      end
    end else if (s_tvalid && s_tready) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    timer_cmd_t c;
    int r;
    logic [31:0] base;
    errors = 0; idle_cycles = 0; no_idle = 0; q_cnt = 0;
    rst = 1'b1; s_tvalid = 1'b0; s_tdata = '0; s_tuser = OP_TICK; m_tready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    table_rows.push_back(mk(OP_TICK,   8'd0,   32'd0, 32'hFFFFFFFF, 1, ST_OK));
    table_rows.push_back(mk(OP_DELETE, 8'd5,   32'd0, 32'd0, 1, ST_ABSENT));
    table_rows.push_back(mk(OP_ADJUST, 8'd5,   32'd0, 32'd0, 1, ST_ABSENT));
    table_rows.push_back(mk(OP_ADD,    8'd0,   32'd0, 32'd0, 1, ST_OK));
    table_rows.push_back(mk(OP_ADD,    8'd255, 32'hFFFFFFFF, 32'd0, 1, ST_OK));
    table_rows.push_back(mk(OP_ADD,    8'd0,   32'd7, 32'd0, 1, ST_FULL));
    table_rows.push_back(mk(OP_ADD,    8'd9,   32'd0, 32'd0, 0, ST_OK));
    table_rows.push_back(mk(OP_ADJUST, 8'd255, 32'd3, 32'd0, 0, ST_OK));
    table_rows.push_back(mk(OP_ADJUST, 8'd0,   32'd100, 32'd0, 0, ST_OK));
    table_rows.push_back(mk(OP_TICK,   8'd0,   32'd0, 32'd2, 0, ST_OK));
    table_rows.push_back(mk(OP_DELETE, 8'd0,   32'd0, 32'd0, 0, ST_OK));
    for (int i = 0; i < 17; i++)
      table_rows.push_back(mk(OP_ADD, 8'(i + 16), 32'(i % 4), 32'd0, 0, ST_OK));
    table_rows.push_back(mk(OP_TICK, 8'd0, 32'd0, 32'hFFFFFFFF, 0, ST_OK));
    foreach (table_rows[i]) send(table_rows[i]);

    base = 32'd0;
    for (int n = 0; n < 300; n++) begin
      if (n == 100) begin
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(negedge clk);
      end
      no_idle = (n >= 150 && n < 200);
      r = $urandom_range(99);
      if (n % 50 == 49) base = $urandom;
      c = mk(OP_ADD, 8'($urandom_range(31)), base + $urandom_range(200),
             base + $urandom_range(200), 0, ST_OK);
      if (r < 5) begin
        c.hnd = 8'($urandom);
        c.expiry = $urandom;
        c.now = $urandom;
      end
      if (r < 40) c.op = OP_ADD;
      else if (r < 60) c.op = OP_ADJUST;
      else if (r < 75) c.op = OP_DELETE;
      else c.op = OP_TICK;
      send(c);
    end
    s_tvalid <= 1'b0;
    no_idle = 0;

    while (pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/stq_pkg.sv
rtl/core/stq_ram.sv
rtl/core/sorted_timer_queue_top.sv
tb/sorted_timer_queue_top_tb.sv
